[rtl/dropout_run_detect_merge_unit_macros.svh]
// ------------------------------------------------------------------------
// Dropout run detect and merge: assertion macros
// Clocked assertion helpers shared by the RTL modules.
// ------------------------------------------------------------------------
`ifndef DROPOUT_RUN_DETECT_MERGE_UNIT_MACROS_SVH
`define DROPOUT_RUN_DETECT_MERGE_UNIT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define DRDM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define DRDM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/drdm_pkg.sv]
// ------------------------------------------------------------------------
// Dropout run detect and merge: package
// Field widths, register map, reset values and transfer types.
// ------------------------------------------------------------------------
package drdm_pkg;

  localparam int X_BITS    = 11;
  localparam int LINE_BITS = 10;
  localparam int HOLD_BITS = 4;
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  // Result queue depth; must be at least two.
  localparam int FIFO_DEPTH = 4;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_AREA_START  = 2'd0;
  localparam logic [1:0] REG_AREA_END    = 2'd1;
  localparam logic [1:0] REG_HOLD_LENGTH = 2'd2;
  localparam logic [1:0] REG_MIN_GAP     = 2'd3;

  localparam logic [X_BITS-1:0]    AREA_START_RST  = X_BITS'(0);
  localparam logic [X_BITS-1:0]    AREA_END_RST    = X_BITS'(2047);
  localparam logic [HOLD_BITS-1:0] HOLD_LENGTH_RST = HOLD_BITS'(5);
  localparam logic [X_BITS-1:0]    MIN_GAP_RST     = X_BITS'(50);

  typedef struct packed {
    logic                 dropout_flag;
    logic [X_BITS-1:0]    pixel_x;
    logic [LINE_BITS-1:0] line_index;
    logic                 last_in_line;
    logic                 last_in_field;
  } in_t;

  typedef struct packed {
    logic [X_BITS-1:0]    run_start;
    logic [X_BITS-1:0]    run_end;
    logic [LINE_BITS:0]   run_line;
    logic                 last_result;
  } out_t;

  typedef struct packed {
    logic [X_BITS-1:0]    area_start;
    logic [X_BITS-1:0]    area_end;
    logic [HOLD_BITS-1:0] hold_length;
    logic [X_BITS-1:0]    min_gap;
  } cfg_t;

  // Results of one item, written into the queue in the same cycle.
  typedef struct packed {
    logic [1:0] num;
    out_t       res0;
    out_t       res1;
  } push_t;

endpackage

[rtl/drdm_regs.sv]
// ------------------------------------------------------------------------
// Dropout run detect and merge: configuration registers
// APB-style register file holding the area, hold length and merge gap.
// ------------------------------------------------------------------------
module drdm_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [drdm_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [drdm_pkg::DATA_BITS-1:0]   pwdata,
  output logic [drdm_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready,
  output drdm_pkg::cfg_t                   cfg_o
);

  drdm_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.area_start  <= drdm_pkg::AREA_START_RST;
      cfg_q.area_end    <= drdm_pkg::AREA_END_RST;
      cfg_q.hold_length <= drdm_pkg::HOLD_LENGTH_RST;
      cfg_q.min_gap     <= drdm_pkg::MIN_GAP_RST;
    end else if (wr_en) begin
      case (reg_idx)
        drdm_pkg::REG_AREA_START:  cfg_q.area_start  <= pwdata[drdm_pkg::X_BITS-1:0];
        drdm_pkg::REG_AREA_END:    cfg_q.area_end    <= pwdata[drdm_pkg::X_BITS-1:0];
        drdm_pkg::REG_HOLD_LENGTH: cfg_q.hold_length <= pwdata[drdm_pkg::HOLD_BITS-1:0];
        drdm_pkg::REG_MIN_GAP:     cfg_q.min_gap     <= pwdata[drdm_pkg::X_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      drdm_pkg::REG_AREA_START:  prdata = drdm_pkg::DATA_BITS'(cfg_q.area_start);
      drdm_pkg::REG_AREA_END:    prdata = drdm_pkg::DATA_BITS'(cfg_q.area_end);
      drdm_pkg::REG_HOLD_LENGTH: prdata = drdm_pkg::DATA_BITS'(cfg_q.hold_length);
      drdm_pkg::REG_MIN_GAP:     prdata = drdm_pkg::DATA_BITS'(cfg_q.min_gap);
      default:                   prdata = '0;
    endcase
  end

endmodule

[rtl/drdm_core.sv]
// ------------------------------------------------------------------------
// Dropout run detect and merge: run tracker
// Input register, open run hold counter and pending merge register.
// ------------------------------------------------------------------------
`include "dropout_run_detect_merge_unit_macros.svh"

module drdm_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  drdm_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  drdm_pkg::in_t   in_data_i,
  input  logic            space_i,
  output drdm_pkg::push_t push_o
);

  localparam int XB = drdm_pkg::X_BITS;
  localparam int LB = drdm_pkg::LINE_BITS;
  localparam int HB = drdm_pkg::HOLD_BITS;

  logic          item_valid_q;
  drdm_pkg::in_t item_q;
  logic          advance;

  logic [HB-1:0] hold_q, hold_d;
  logic [XB-1:0] open_start_q, open_start_d;
  logic [LB:0]   open_line_q, open_line_d;
  logic          pend_valid_q, pend_valid_d;
  logic [XB-1:0] pend_start_q, pend_start_d;
  logic [XB-1:0] pend_end_q, pend_end_d;
  logic [LB:0]   pend_line_q, pend_line_d;

  logic          in_area, closed, merge;
  logic [XB-1:0] cs, ce;
  logic [LB:0]   cl;
  logic [XB:0]   reach;
  logic [HB-1:0] hold_load;
  logic [1:0]    num;
  drdm_pkg::out_t res0, res1;

  function automatic drdm_pkg::out_t make_res(logic [XB-1:0] s, logic [XB-1:0] e,
                                              logic [LB:0] l);
    drdm_pkg::out_t r;
    r.run_start   = s;
    r.run_end     = e;
    r.run_line    = l;
    r.last_result = 1'b0;
    return r;
  endfunction

  assign advance    = item_valid_q & space_i;
  assign in_ready_o = ~item_valid_q | space_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  always_comb begin
    hold_d       = hold_q;
    open_start_d = open_start_q;
    open_line_d  = open_line_q;
    pend_valid_d = pend_valid_q;
    pend_start_d = pend_start_q;
    pend_end_d   = pend_end_q;
    pend_line_d  = pend_line_q;
    closed       = 1'b0;
    cs           = '0;
    ce           = '0;
    cl           = '0;
    num          = 2'd0;
    res0         = '0;
    res1         = '0;

    in_area   = (item_q.pixel_x >= cfg_i.area_start) && (item_q.pixel_x < cfg_i.area_end);
    hold_load = (cfg_i.hold_length == '0) ? HB'(1) : cfg_i.hold_length;

    if (in_area) begin
      if (item_q.dropout_flag) begin
        if (hold_q == '0) begin
          hold_d       = hold_load;
          open_start_d = item_q.pixel_x;
          open_line_d  = {1'b0, item_q.line_index} + (LB+1)'(1);
        end
      end else if (hold_q != '0) begin
        hold_d = hold_q - HB'(1);
        if (hold_d == '0) begin
          closed = 1'b1;
          cs     = open_start_q;
          ce     = item_q.pixel_x - XB'(1);
          cl     = open_line_q;
        end
      end
    end

    // Line or field end closes whatever is still open.
    if ((item_q.last_in_line || item_q.last_in_field) && hold_d != '0) begin
      hold_d = '0;
      closed = 1'b1;
      cs     = open_start_d;
      ce     = cfg_i.area_end;
      cl     = open_line_d;
    end

    reach = {1'b0, pend_end_q} + {1'b0, cfg_i.min_gap};
    merge = pend_valid_q && (pend_line_q == cl) && (reach > {1'b0, cs});

    if (closed) begin
      if (merge) begin
        pend_end_d = ce;
      end else begin
        if (pend_valid_q) begin
          res0 = make_res(pend_start_q, pend_end_q, pend_line_q);
          num  = 2'd1;
        end
        pend_valid_d = 1'b1;
        pend_start_d = cs;
        pend_end_d   = ce;
        pend_line_d  = cl;
      end
    end

    // Flush the pending run at field end.
    if (item_q.last_in_field && pend_valid_d) begin
      if (num == 2'd0) begin
        res0 = make_res(pend_start_d, pend_end_d, pend_line_d);
      end else begin
        res1 = make_res(pend_start_d, pend_end_d, pend_line_d);
      end
      num          = num + 2'd1;
      pend_valid_d = 1'b0;
    end

    if (num == 2'd1) begin
      res0.last_result = 1'b1;
    end
    if (num == 2'd2) begin
      res1.last_result = 1'b1;
    end
  end

  assign push_o.num  = advance ? num : 2'd0;
  assign push_o.res0 = res0;
  assign push_o.res1 = res1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q       <= '0;
      open_start_q <= '0;
      open_line_q  <= '0;
      pend_valid_q <= 1'b0;
      pend_start_q <= '0;
      pend_end_q   <= '0;
      pend_line_q  <= '0;
    end else if (advance) begin
      hold_q       <= hold_d;
      open_start_q <= open_start_d;
      open_line_q  <= open_line_d;
      pend_valid_q <= pend_valid_d;
      pend_start_q <= pend_start_d;
      pend_end_q   <= pend_end_d;
      pend_line_q  <= pend_line_d;
    end
  end

  `DRDM_ASSERT(a_field_end_flushes, advance && item_q.last_in_field |=> !pend_valid_q, "pending run survived field end")
  `DRDM_ASSERT(a_line_end_closes, advance && (item_q.last_in_line || item_q.last_in_field) |=> hold_q == '0, "run still open after line end")

endmodule

[rtl/drdm_fifo.sv]
// ------------------------------------------------------------------------
// Dropout run detect and merge: result queue
// Register queue taking up to two results a cycle, handing out one when the output is ready.
// ------------------------------------------------------------------------
`include "dropout_run_detect_merge_unit_macros.svh"

module drdm_fifo #(
  parameter int DEPTH = drdm_pkg::FIFO_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  drdm_pkg::push_t push_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output drdm_pkg::out_t  out_data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  drdm_pkg::out_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, wr_ptr1, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign space_o     = count_q <= CNT_W'(DEPTH - 2);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & out_ready_i;
  assign wr_ptr1     = ptr_inc(wr_ptr_q);

  always_comb begin
    case (push_i.num)
      2'd0:    wr_ptr_d = wr_ptr_q;
      2'd1:    wr_ptr_d = wr_ptr1;
      default: wr_ptr_d = ptr_inc(wr_ptr1);
    endcase
    count_d = count_q + CNT_W'(push_i.num) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr1] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
    end
  end

  `DRDM_ASSERT_NEVER(a_no_overflow, count_q > CNT_W'(DEPTH), "result queue overflow")
  `DRDM_ASSERT(a_push_has_room, push_i.num != 2'd0 |-> count_q <= CNT_W'(DEPTH - 2), "push without room for two results")

endmodule

[rtl/dropout_run_detect_merge_unit.sv]
// An accepted pixel is held in the input register until the result queue has room; its
//   results are then written into the result queue, from which the output reads them.
// Throughput: one pixel per cycle while the result queue has room; results leave it one per
//   cycle while the output is ready, so a pixel that yields two results uses two transfers.
// Input stalls only when the result queue cannot take two more results.
// Reset (asynchronous, active low) clears the open run, the pending run, the queue
//   and sets the registers to their defaults.
// ------------------------------------------------------------------------
// Dropout run detect and merge unit
// Turns per-pixel dropout flags into merged dropout runs for one field.
// ------------------------------------------------------------------------
module dropout_run_detect_merge_unit #(
  parameter int FIFO_DEPTH = drdm_pkg::FIFO_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  drdm_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output drdm_pkg::out_t                 out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [drdm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [drdm_pkg::DATA_BITS-1:0] pwdata,
  output logic [drdm_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);

  drdm_pkg::cfg_t  cfg;
  drdm_pkg::push_t push;
  logic            space;

  drdm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  drdm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .space_i    (space),
    .push_o     (push)
  );

  drdm_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// Dropout run detect and merge unit: testbench
// Sends pixel flags under random valid/ready idling and register writes,
// predicts the merged dropout runs of every pixel and checks each run
// transfer field by field, in order, against the prediction.
// ------------------------------------------------------------------------
module tb_top;

  localparam int XB   = drdm_pkg::X_BITS;
  localparam int LB   = drdm_pkg::LINE_BITS;
  localparam int HB   = drdm_pkg::HOLD_BITS;
  localparam int AB   = drdm_pkg::ADDR_BITS;
  localparam int DB   = drdm_pkg::DATA_BITS;
  localparam int CW   = XB + 1;
  localparam int IN_W = $bits(drdm_pkg::in_t);

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int LONG_HOLD      = 200;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  drdm_pkg::in_t        in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  drdm_pkg::out_t       out_data_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AB-1:0]        paddr;
  logic [DB-1:0]        pwdata;
  logic [DB-1:0]        prdata;
  logic                 pready;

  dropout_run_detect_merge_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Register copies and run state of the predictor
  logic [XB-1:0] cfg_area_start  = drdm_pkg::AREA_START_RST;
  logic [XB-1:0] cfg_area_end    = drdm_pkg::AREA_END_RST;
  logic [HB-1:0] cfg_hold_length = drdm_pkg::HOLD_LENGTH_RST;
  logic [XB-1:0] cfg_min_gap     = drdm_pkg::MIN_GAP_RST;

  logic [HB-1:0] hold_cnt   = '0;
  logic [XB-1:0] open_start = '0;
  logic [LB:0]   open_line  = '0;
  bit            pend_valid = 1'b0;
  logic [XB-1:0] pend_start = '0;
  logic [XB-1:0] pend_end   = '0;
  logic [LB:0]   pend_line  = '0;

  drdm_pkg::out_t runs_due[$];

  int pixels_sent   = 0;
  int runs_seen     = 0;
  int merges_seen   = 0;
  int double_pixels = 0;
  int reg_writes    = 0;
  int errors        = 0;
  int line_no       = 0;

  bit src_gaps   = 1'b1;
  bit snk_gaps   = 1'b1;
  int hold_req   = 0;
  int stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Advance the run state by one pixel and queue the runs it releases
  function automatic void predict_runs(input drdm_pkg::in_t px);
    logic           closed;
    logic [XB-1:0]  cs;
    logic [XB-1:0]  ce;
    logic [LB:0]    cl;
    drdm_pkg::out_t found [2];
    int             n;
    closed = 1'b0;
    cs = '0;
    ce = '0;
    cl = '0;
    n = 0;
    if (px.pixel_x >= cfg_area_start && px.pixel_x < cfg_area_end) begin
      if (px.dropout_flag) begin
        if (hold_cnt == 0) begin
          hold_cnt = (cfg_hold_length == 0) ? HB'(1) : cfg_hold_length;
          open_start = px.pixel_x;
          open_line = {1'b0, px.line_index} + (LB+1)'(1);
        end
      end else if (hold_cnt != 0) begin
        hold_cnt = hold_cnt - HB'(1);
        if (hold_cnt == 0) begin
          closed = 1'b1;
          cs = open_start;
          ce = px.pixel_x - XB'(1);
          cl = open_line;
        end
      end
    end
    // a line or field end closes an open run at the area end
    if ((px.last_in_line || px.last_in_field) && hold_cnt != 0) begin
      hold_cnt = '0;
      closed = 1'b1;
      cs = open_start;
      ce = cfg_area_end;
      cl = open_line;
    end
    if (closed) begin
      if (pend_valid && pend_line == cl &&
          ({1'b0, pend_end} + {1'b0, cfg_min_gap}) > {1'b0, cs}) begin
        pend_end = ce;
        merges_seen++;
      end else begin
        if (pend_valid) begin
          found[n] = '{run_start: pend_start, run_end: pend_end, run_line: pend_line,
                       last_result: 1'b0};
          n++;
        end
        pend_valid = 1'b1;
        pend_start = cs;
        pend_end = ce;
        pend_line = cl;
      end
    end
    if (px.last_in_field && pend_valid) begin
      found[n] = '{run_start: pend_start, run_end: pend_end, run_line: pend_line,
                   last_result: 1'b0};
      n++;
      pend_valid = 1'b0;
    end
    if (n != 0) found[n-1].last_result = 1'b1;
    for (int k = 0; k < n; k++) runs_due.push_back(found[k]);
    if (n == 2) double_pixels++;
  endfunction

  function automatic drdm_pkg::in_t pixel(input bit flag, input int x, input int ln,
                                          input bit eol, input bit eof);
    drdm_pkg::in_t px;
    px.dropout_flag = flag;
    px.pixel_x = x[XB-1:0];
    px.line_index = ln[LB-1:0];
    px.last_in_line = eol;
    px.last_in_field = eof;
    return px;
  endfunction

  task automatic send_pixel(input drdm_pkg::in_t px);
    int gap;
    gap = src_gaps ? $urandom_range(8, 0) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_runs(px);
    pixels_sent++;
  endtask

  // Drop valid and hold until every predicted run has been seen
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DB-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      drdm_pkg::REG_AREA_START:  cfg_area_start = value[XB-1:0];
      drdm_pkg::REG_AREA_END:    cfg_area_end = value[XB-1:0];
      drdm_pkg::REG_HOLD_LENGTH: cfg_hold_length = value[HB-1:0];
      drdm_pkg::REG_MIN_GAP:     cfg_min_gap = value[XB-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One line of pixels around the area, flags in bursts, some noise items
  task automatic send_line();
    drdm_pkg::in_t    px;
    logic [IN_W-1:0]  raw;
    int               len;
    int               x;
    int               lo;
    int               hi;
    int               step;
    int               i;
    bit               burst;
    bit               field_end;
    bit               split;
    bit               tail;
    len = $urandom_range(48, 6);
    lo = (cfg_area_start > 4) ? cfg_area_start - 4 : 0;
    hi = cfg_area_end;
    if (hi > 2047 - len) hi = 2047 - len;
    if (hi < lo) hi = lo;
    x = $urandom_range(hi, lo);
    burst = 1'b0;
    field_end = ($urandom_range(5, 0) == 0);
    split = ($urandom_range(3, 0) == 0);
    src_gaps = ($urandom_range(3, 0) != 0);
    snk_gaps = ($urandom_range(3, 0) != 0);
    tail = 1'b0;
    i = 0;
    while (!tail) begin
      if ($urandom_range(5, 0) == 0) burst = !burst;
      step = ($urandom_range(15, 0) == 0) ? $urandom_range(5, 2) : 1;
      tail = (i == len - 1) || (x + step > 2047);
      px = pixel(burst ? ($urandom_range(3, 0) != 0) : ($urandom_range(9, 0) == 0),
                 x, line_no, tail && !(field_end && split), tail && field_end);
      if ($urandom_range(11, 0) == 0) begin
        raw = IN_W'($urandom);
        px = raw;
      end
      send_pixel(px);
      x += step;
      i++;
    end
    case ($urandom_range(7, 0))
      0: line_no = $urandom_range(1023, 0);
      1: ;
      default: line_no = (line_no + 1) % 1024;
    endcase
  endtask

  task automatic run_phase(input int a_start, input int a_end, input int hold,
                           input int gap, input int count);
    int target;
    wait_drained();
    write_reg(drdm_pkg::REG_AREA_START, a_start);
    write_reg(drdm_pkg::REG_AREA_END, a_end);
    write_reg(drdm_pkg::REG_HOLD_LENGTH, hold);
    write_reg(drdm_pkg::REG_MIN_GAP, gap);
    target = pixels_sent + count;
    while (pixels_sent < target) send_line();
  endtask

  // Default registers: open, hold without reload, close, merge, line end, flush
  task automatic test_single_line_runs();
    send_pixel(pixel(1'b1, 10, 0, 1'b0, 1'b0));
    send_pixel(pixel(1'b1, 11, 0, 1'b0, 1'b0));
    for (int x = 12; x <= 16; x++) send_pixel(pixel(1'b0, x, 0, 1'b0, 1'b0));
    send_pixel(pixel(1'b1, 40, 0, 1'b0, 1'b0));
    send_pixel(pixel(1'b0, 41, 0, 1'b1, 1'b0));
    send_pixel(pixel(1'b1, 2046, 1, 1'b0, 1'b0));
    // outside the area, but the field end still closes and flushes two runs
    send_pixel(pixel(1'b0, 2047, 1, 1'b0, 1'b1));
  endtask

  task automatic test_edge_cases();
    wait_drained();
    write_reg(drdm_pkg::REG_AREA_START, 0);
    write_reg(drdm_pkg::REG_AREA_END, 2047);
    write_reg(drdm_pkg::REG_HOLD_LENGTH, 0);
    write_reg(drdm_pkg::REG_MIN_GAP, 2047);
    // close at x = 0 wraps the end position; last line gives run line 1024
    send_pixel(pixel(1'b1, 5, 1023, 1'b0, 1'b0));
    send_pixel(pixel(1'b0, 0, 1023, 1'b0, 1'b0));
    // merge sum exceeds the x range
    send_pixel(pixel(1'b1, 2046, 1023, 1'b0, 1'b0));
    send_pixel(pixel(1'b0, 2047, 1023, 1'b1, 1'b0));
    // run keeps its opening line across a line change
    send_pixel(pixel(1'b1, 100, 5, 1'b0, 1'b0));
    send_pixel(pixel(1'b1, 101, 7, 1'b0, 1'b0));
    send_pixel(pixel(1'b0, 102, 7, 1'b0, 1'b0));
    // field end without line end
    send_pixel(pixel(1'b1, 200, 7, 1'b0, 1'b1));
    wait_drained();
    write_reg(drdm_pkg::REG_AREA_START, 300);
    write_reg(drdm_pkg::REG_AREA_END, 300);
    write_reg(drdm_pkg::REG_HOLD_LENGTH, 15);
    send_pixel(pixel(1'b1, 300, 0, 1'b0, 1'b0));
    send_pixel(pixel(1'b1, 299, 0, 1'b0, 1'b0));
    send_pixel(pixel(1'b0, 0, 0, 1'b1, 1'b1));
    wait_drained();
    write_reg(drdm_pkg::REG_AREA_START, 2047);
    write_reg(drdm_pkg::REG_AREA_END, 0);
    send_pixel(pixel(1'b1, 2047, 1023, 1'b1, 1'b1));
  endtask

  task automatic test_random_traffic();
    int a_start;
    run_phase(0, 2047, 15, 2047, 210);
    run_phase(0, 2047, 1, 0, 210);
    run_phase(100, 160, 3, 10, 210);
    run_phase(1990, 2047, 2, 4, 210);
    repeat (2) begin
      a_start = $urandom_range(1900, 0);
      run_phase(a_start, a_start + $urandom_range(147, 1), $urandom_range(15, 1),
                $urandom_range(60, 0), 210);
    end
  endtask

  // Hold the result side for a long stretch while pixels keep coming
  task automatic test_result_backpressure();
    wait_drained();
    write_reg(drdm_pkg::REG_AREA_START, 0);
    write_reg(drdm_pkg::REG_AREA_END, 2047);
    write_reg(drdm_pkg::REG_HOLD_LENGTH, 1);
    write_reg(drdm_pkg::REG_MIN_GAP, 0);
    src_gaps = 1'b0;
    snk_gaps = 1'b0;
    hold_req = LONG_HOLD;
    for (int i = 0; i < 120; i++) begin
      send_pixel(pixel(i % 2 == 0, 300 + i, 10, i == 119, i == 119));
    end
    wait_drained();
    src_gaps = 1'b1;
    snk_gaps = 1'b1;
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_line_runs();
    test_edge_cases();
    test_result_backpressure();
    test_random_traffic();
    wait_drained();

    $display("%0d pixels sent, %0d runs checked, %0d merges, %0d pixels closing two runs",
             pixels_sent, runs_seen, merges_seen, double_pixels);
    $display("%0d register writes across area, hold and gap settings incl. extremes",
             reg_writes);
    if (errors == 0) begin
      $display("dropout_run_detect_merge_unit: match");
    end else begin
      $display("dropout_run_detect_merge_unit: mismatch");
    end
    $finish;
  end

  // Result side ready, with drawn stalls and the long hold-off
  initial begin : result_sink
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic check_field(input string field, input logic [CW-1:0] want_v,
                             input logic [CW-1:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin : check_runs
    drdm_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      runs_seen++;
      stall_left = snk_gaps ? $urandom_range(8, 0) : 0;
      if (runs_due.size() == 0) begin
        errors++;
        $display("%0t: run expected none actual %0d..%0d line %0d", $time,
                 out_data_o.run_start, out_data_o.run_end, out_data_o.run_line);
      end else begin
        want = runs_due.pop_front();
        check_field("run_start", CW'(want.run_start), CW'(out_data_o.run_start));
        check_field("run_end", CW'(want.run_end), CW'(out_data_o.run_end));
        check_field("run_line", CW'(want.run_line), CW'(out_data_o.run_line));
        check_field("last_result", CW'(want.last_result), CW'(out_data_o.last_result));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles, %0d runs outstanding", $time,
             WATCHDOG_LIMIT, runs_due.size());
    $display("dropout_run_detect_merge_unit: mismatch");
    $finish;
  end

endmodule
